/* hdl/rigid_body_collision_response_defines.svh */
// Assertion macros shared by the collision response RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef RIGID_BODY_COLLISION_RESPONSE_DEFINES_SVH
`define RIGID_BODY_COLLISION_RESPONSE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RBCR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Condition that must never be seen outside reset.
`define RBCR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`endif

/* hdl/rbcr_pkg.sv */
// Types, widths and helpers for the collision response pipeline.
// Used by every module of the block; depends on nothing.
package rbcr_pkg;

  localparam int VEL_W      = 24;
  localparam int MASS_W     = 16;
  localparam int ELAST_W    = 9;
  localparam int ESUM_W     = 10;
  localparam int MSUM_W     = 17;
  localparam int PROD_W     = 41;
  localparam int DV_W       = 25;
  localparam int EM_W       = 26;
  localparam int NUM_W      = 52;
  localparam int DEN_SHIFT  = 9;
  localparam int DEN_W      = MSUM_W + DEN_SHIFT;
  localparam int QUO_W      = 27;
  localparam int VMAG_W     = 28;
  localparam int BMAG_W     = VMAG_W + ELAST_W;
  localparam int ROUND_SH   = 8;
  localparam int NCOMP      = 4;
  localparam int FRONT_LAT  = 4;
  localparam int POST_LAT   = 2;
  localparam int LAT        = FRONT_LAT + QUO_W + POST_LAT;

  // Velocity component slots.
  localparam int COMP_AX = 0;
  localparam int COMP_AY = 1;
  localparam int COMP_BX = 2;
  localparam int COMP_BY = 3;

  // What travels alongside the arithmetic: valid bit, case flags, echo values.
  typedef struct packed {
    logic                     valid;
    logic                     static_a;
    logic                     static_b;
    logic                     axis_is_x;
    logic [ELAST_W-1:0]       elast_a;
    logic [ELAST_W-1:0]       elast_b;
    logic signed [VEL_W-1:0]  vxa;
    logic signed [VEL_W-1:0]  vya;
    logic signed [VEL_W-1:0]  vxb;
    logic signed [VEL_W-1:0]  vyb;
  } side_t;

  function automatic logic [VEL_W-1:0] vel_mag(logic signed [VEL_W-1:0] v);
    return v[VEL_W-1] ? VEL_W'(-v) : v;
  endfunction

endpackage

/* hdl/rigid_body_collision_response.sv */
// Top level of the two-body collision response pipeline.
// Depends on rbcr_pkg, rbcr_front, rbcr_div, rbcr_post and the defines header.
//
//   Channel   Handshake            Word
//   -------   ------------------   ---------------------------------------------
//   input     start, busy          two bodies (velocity, mass, elasticity, flag)
//                                  and the bounce axis
//   result    done_o (strobe)      four new velocities and the saturation flag
//
// One word is taken in every cycle; busy never rises. Each result passes
// through four front stages, a 27-stage restoring divider that settles one
// quotient bit per stage, and two stages for bounce scaling and clipping.
// Reset clears every valid bit at once, so no result follows reset until a
// new word enters. The receiver cannot hold a result, and the pipeline
// never stalls.
`include "rigid_body_collision_response_defines.svh"
module rigid_body_collision_response (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rbcr_pkg::VEL_W-1:0]    vel_x_a_i,
  input  logic signed [rbcr_pkg::VEL_W-1:0]    vel_y_a_i,
  input  logic [rbcr_pkg::MASS_W-1:0]          mass_a_i,
  input  logic [rbcr_pkg::ELAST_W-1:0]         elast_a_i,
  input  logic                                 static_a_i,
  input  logic signed [rbcr_pkg::VEL_W-1:0]    vel_x_b_i,
  input  logic signed [rbcr_pkg::VEL_W-1:0]    vel_y_b_i,
  input  logic [rbcr_pkg::MASS_W-1:0]          mass_b_i,
  input  logic [rbcr_pkg::ELAST_W-1:0]         elast_b_i,
  input  logic                                 static_b_i,
  input  logic                                 axis_is_x_i,
  output logic                                 done_o,
  output logic signed [rbcr_pkg::VEL_W-1:0]    new_vx_a_o,
  output logic signed [rbcr_pkg::VEL_W-1:0]    new_vy_a_o,
  output logic signed [rbcr_pkg::VEL_W-1:0]    new_vx_b_o,
  output logic signed [rbcr_pkg::VEL_W-1:0]    new_vy_b_o,
  output logic                                 saturated_o
);
  import rbcr_pkg::*;

  side_t                       side_in, side_f;
  side_t                       side_q [QUO_W];
  logic [NCOMP-1:0][NUM_W-1:0] mag_f;
  logic [NCOMP-1:0]            neg_f, neg_d;
  logic [DEN_W-1:0]            den_f;
  logic [NCOMP-1:0][QUO_W-1:0] quo_d;
  logic [NCOMP-1:0][VEL_W-1:0] vel_out;

  // The pipeline always advances, so it is never busy.
  assign busy = 1'b0;

  always_comb begin
    side_in.valid     = start;
    side_in.static_a  = static_a_i;
    side_in.static_b  = static_b_i;
    side_in.axis_is_x = axis_is_x_i;
    side_in.elast_a   = elast_a_i;
    side_in.elast_b   = elast_b_i;
    side_in.vxa       = vel_x_a_i;
    side_in.vya       = vel_y_a_i;
    side_in.vxb       = vel_x_b_i;
    side_in.vyb       = vel_y_b_i;
  end

  // Numerators are N = 512*(ms*vs + mt*vt) + E*mt*(vt - vs); the divisor is
  // 512*(ma + mb), shared by all four components.
  rbcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .side_i  (side_in),
    .mass_a_i(mass_a_i),
    .mass_b_i(mass_b_i),
    .side_o  (side_f),
    .mag_o   (mag_f),
    .neg_o   (neg_f),
    .den_o   (den_f)
  );

  // One divider per velocity component, all fed the same divisor.
  for (genvar k = 0; k < NCOMP; k++) begin : g_div
    rbcr_div u_div (
      .clk_i(clk_i),
      .mag_i(mag_f[k]),
      .den_i(den_f),
      .neg_i(neg_f[k]),
      .quo_o(quo_d[k]),
      .neg_o(neg_d[k])
    );
  end

  // The case flags and echo values ride along with the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QUO_W; k++) side_q[k] <= '0;
    end else begin
      side_q[0] <= side_f;
      for (int k = 1; k < QUO_W; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Case selection: a static body echoes its word, a moving body facing a
  // static one bounces, two moving bodies take their collision velocities.
  rbcr_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .side_i     (side_q[QUO_W-1]),
    .quo_i      (quo_d),
    .neg_i      (neg_d),
    .done_o     (done_o),
    .vel_o      (vel_out),
    .saturated_o(saturated_o)
  );

  assign new_vx_a_o = vel_out[COMP_AX];
  assign new_vy_a_o = vel_out[COMP_AY];
  assign new_vx_b_o = vel_out[COMP_BX];
  assign new_vy_b_o = vel_out[COMP_BY];

  `RBCR_ASSERT_IMP(a_done_has_word, clk_i, rst_ni, done_o, $past(start, LAT), "result without word")
  `RBCR_ASSERT_NEVER(a_sat_only_on_done, clk_i, rst_ni, saturated_o && !done_o, "stray saturation flag")
  `RBCR_ASSERT_IMP(a_static_a_echo, clk_i, rst_ni, done_o && $past(static_a_i, LAT), (new_vx_a_o == $past(vel_x_a_i, LAT)) && (new_vy_a_o == $past(vel_y_a_i, LAT)), "static body A not echoed")
  `RBCR_ASSERT_IMP(a_both_static_nosat, clk_i, rst_ni, done_o && $past(static_a_i && static_b_i, LAT), !saturated_o, "echo flagged as saturated")

endmodule

/* hdl/rbcr_front.sv */
// Front end: products, difference terms and the signed numerators.
// Depends on rbcr_pkg.
module rbcr_front (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  rbcr_pkg::side_t                                side_i,
  input  logic [rbcr_pkg::MASS_W-1:0]                    mass_a_i,
  input  logic [rbcr_pkg::MASS_W-1:0]                    mass_b_i,
  output rbcr_pkg::side_t                                side_o,
  output logic [rbcr_pkg::NCOMP-1:0][rbcr_pkg::NUM_W-1:0] mag_o,
  output logic [rbcr_pkg::NCOMP-1:0]                     neg_o,
  output logic [rbcr_pkg::DEN_W-1:0]                     den_o
);
  import rbcr_pkg::*;

  side_t side_q [FRONT_LAT];

  logic [MASS_W-1:0]               ma, mb;
  logic [ESUM_W-1:0]               esum;
  logic signed [PROD_W-1:0]        p_ax_q, p_ay_q, p_bx_q, p_by_q;
  logic signed [DV_W-1:0]          dv_x_q, dv_y_q;
  logic [EM_W-1:0]                 em_a_q, em_b_q;
  logic [MSUM_W-1:0]               msum_q;
  logic signed [PROD_W-1:0]        px_q, py_q;
  logic [NCOMP-1:0][NUM_W-1:0]     t_q;
  logic [NCOMP-1:0][NUM_W-1:0]     n_q;
  logic [DEN_W-1:0]                den2_q, den3_q, den4_q;
  logic [NCOMP-1:0][NUM_W-1:0]     mag_q;
  logic [NCOMP-1:0]                neg_q;

  // A zero mass is taken as one.
  assign ma   = (mass_a_i == '0) ? MASS_W'(1) : mass_a_i;
  assign mb   = (mass_b_i == '0) ? MASS_W'(1) : mass_b_i;
  assign esum = ESUM_W'(side_i.elast_a) + ESUM_W'(side_i.elast_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRONT_LAT; k++) side_q[k] <= '0;
    end else begin
      side_q[0] <= side_i;
      for (int k = 1; k < FRONT_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Stage 1: mass times velocity, elasticity sum times mass, differences, mass sum.
  always_ff @(posedge clk_i) begin
    p_ax_q <= PROD_W'($signed({1'b0, ma})) * PROD_W'(side_i.vxa);
    p_ay_q <= PROD_W'($signed({1'b0, ma})) * PROD_W'(side_i.vya);
    p_bx_q <= PROD_W'($signed({1'b0, mb})) * PROD_W'(side_i.vxb);
    p_by_q <= PROD_W'($signed({1'b0, mb})) * PROD_W'(side_i.vyb);
    dv_x_q <= DV_W'(side_i.vxb) - DV_W'(side_i.vxa);
    dv_y_q <= DV_W'(side_i.vyb) - DV_W'(side_i.vya);
    em_a_q <= EM_W'(esum) * EM_W'(ma);
    em_b_q <= EM_W'(esum) * EM_W'(mb);
    msum_q <= MSUM_W'(ma) + MSUM_W'(mb);
  end

  // Stage 2: momentum sums and the elasticity correction terms.
  always_ff @(posedge clk_i) begin
    px_q   <= p_ax_q + p_bx_q;
    py_q   <= p_ay_q + p_by_q;
    t_q[COMP_AX] <= NUM_W'($signed({1'b0, em_b_q})) * NUM_W'(dv_x_q);
    t_q[COMP_AY] <= NUM_W'($signed({1'b0, em_b_q})) * NUM_W'(dv_y_q);
    t_q[COMP_BX] <= NUM_W'($signed({1'b0, em_a_q})) * (NUM_W'(0) - NUM_W'(dv_x_q));
    t_q[COMP_BY] <= NUM_W'($signed({1'b0, em_a_q})) * (NUM_W'(0) - NUM_W'(dv_y_q));
    den2_q <= {msum_q, {DEN_SHIFT{1'b0}}};
  end

  // Stage 3: full numerators.
  always_ff @(posedge clk_i) begin
    n_q[COMP_AX] <= (NUM_W'(px_q) << DEN_SHIFT) + t_q[COMP_AX];
    n_q[COMP_BX] <= (NUM_W'(px_q) << DEN_SHIFT) + t_q[COMP_BX];
    n_q[COMP_AY] <= (NUM_W'(py_q) << DEN_SHIFT) + t_q[COMP_AY];
    n_q[COMP_BY] <= (NUM_W'(py_q) << DEN_SHIFT) + t_q[COMP_BY];
    den3_q <= den2_q;
  end

  // Stage 4: magnitude plus half the divisor for round-half-away.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NCOMP; k++) begin
      neg_q[k] <= n_q[k][NUM_W-1];
      mag_q[k] <= (n_q[k][NUM_W-1] ? (NUM_W'(0) - n_q[k]) : n_q[k])
                  + NUM_W'(den3_q >> 1);
    end
    den4_q <= den3_q;
  end

  assign side_o = side_q[FRONT_LAT-1];
  assign mag_o  = mag_q;
  assign neg_o  = neg_q;
  assign den_o  = den4_q;

endmodule

/* hdl/rbcr_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rbcr_pkg.
module rbcr_div (
  input  logic                         clk_i,
  input  logic [rbcr_pkg::NUM_W-1:0]   mag_i,
  input  logic [rbcr_pkg::DEN_W-1:0]   den_i,
  input  logic                         neg_i,
  output logic [rbcr_pkg::QUO_W-1:0]   quo_o,
  output logic                         neg_o
);
  import rbcr_pkg::*;

  logic [NUM_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             neg_q [QUO_W];

  // The quotient is known to stay below 2**QUO_W, so each stage needs
  // only one compare against the divisor shifted into place.
  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_in, sub;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             neg_in, ge;

    if (k == 0) begin : g_first
      assign rem_in = mag_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign sub = NUM_W'(den_in) << (QUO_W - 1 - k);
    assign ge  = (rem_in >= sub);

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      neg_q[k] <= neg_in;
    end

    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? (rem_in - sub) : rem_in;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign neg_o = neg_q[QUO_W-1];

endmodule

/* hdl/rbcr_post.sv */
// Back end: case selection, bounce scaling, rounding and saturation.
// Depends on rbcr_pkg.
module rbcr_post (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  rbcr_pkg::side_t                                 side_i,
  input  logic [rbcr_pkg::NCOMP-1:0][rbcr_pkg::QUO_W-1:0] quo_i,
  input  logic [rbcr_pkg::NCOMP-1:0]                      neg_i,
  output logic                                            done_o,
  output logic [rbcr_pkg::NCOMP-1:0][rbcr_pkg::VEL_W-1:0] vel_o,
  output logic                                            saturated_o
);
  import rbcr_pkg::*;

  logic [NCOMP-1:0][VEL_W-1:0]  vin;
  logic [NCOMP-1:0][VMAG_W-1:0] mag1;
  logic [NCOMP-1:0]             neg1, bnc1;
  logic [NCOMP-1:0][ELAST_W-1:0] e1;
  logic [NCOMP-1:0][BMAG_W-1:0] val_q;
  logic [NCOMP-1:0]             neg_q, bnc_q;
  logic                         vld_q;

  logic [NCOMP-1:0][BMAG_W-1:0] m2, lim2;
  logic [NCOMP-1:0]             sat2;
  logic [NCOMP-1:0][VEL_W-1:0]  out2;
  logic                         done_q, sat_q;
  logic [NCOMP-1:0][VEL_W-1:0]  vel_q;

  assign vin[COMP_AX] = side_i.vxa;
  assign vin[COMP_AY] = side_i.vya;
  assign vin[COMP_BX] = side_i.vxb;
  assign vin[COMP_BY] = side_i.vyb;

  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      if (k < COMP_BX) begin
        e1[k] = side_i.elast_a;
        if (side_i.static_a) begin
          mag1[k] = VMAG_W'(vel_mag(vin[k]));
          neg1[k] = vin[k][VEL_W-1];
          bnc1[k] = 1'b0;
        end else begin
          mag1[k] = VMAG_W'(quo_i[k]);
          neg1[k] = neg_i[k];
          bnc1[k] = side_i.static_b;
        end
      end else begin
        e1[k] = side_i.elast_b;
        if (side_i.static_a || side_i.static_b) begin
          mag1[k] = VMAG_W'(vel_mag(vin[k]));
          neg1[k] = vin[k][VEL_W-1];
          bnc1[k] = side_i.static_a && !side_i.static_b;
        end else begin
          mag1[k] = VMAG_W'(quo_i[k]);
          neg1[k] = neg_i[k];
          bnc1[k] = 1'b0;
        end
      end
      // The component along the bounce axis flips sign.
      if (bnc1[k] && ((k == COMP_AX || k == COMP_BX) == side_i.axis_is_x)) begin
        neg1[k] = !neg1[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= side_i.valid;
      done_q <= vld_q;
    end
  end

  // Stage 1: scale the bouncing magnitudes by the elasticity.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NCOMP; k++) begin
      val_q[k] <= bnc1[k] ? (BMAG_W'(mag1[k]) * BMAG_W'(e1[k])) : BMAG_W'(mag1[k]);
      neg_q[k] <= neg1[k];
      bnc_q[k] <= bnc1[k];
    end
  end

  // Stage 2: round, restore the sign and clip to the velocity range.
  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      m2[k]   = bnc_q[k] ? ((val_q[k] + BMAG_W'(1 << (ROUND_SH - 1))) >> ROUND_SH)
                         : val_q[k];
      lim2[k] = neg_q[k] ? BMAG_W'(1 << (VEL_W - 1)) : BMAG_W'((1 << (VEL_W - 1)) - 1);
      sat2[k] = (m2[k] > lim2[k]);
      out2[k] = sat2[k] ? lim2[k][VEL_W-1:0] : m2[k][VEL_W-1:0];
      if (neg_q[k]) out2[k] = VEL_W'(0) - out2[k];
    end
  end

  always_ff @(posedge clk_i) begin
    vel_q <= out2;
    sat_q <= |sat2;
  end

  assign done_o      = done_q;
  assign vel_o       = vel_q;
  assign saturated_o = done_q && sat_q;

endmodule
